@@ sv/wpool_pkg.sv @@
// ----------------------------------------------------------------------------
// wpool_pkg: shared types and constants for the window pooling block
// Configuration layout, register indexes, state encodings, fixed widths.
// ----------------------------------------------------------------------------
`default_nettype none

package wpool_pkg;

  // Fixed arithmetic widths
  localparam int ACC_W     = 32;  // accumulator width, saturating
  localparam int FRAC_BITS = 12;  // fraction bits of the pixel format

  // Configuration register widths
  localparam int WIN_REG_W   = 5;
  localparam int OUT_REG_W   = 9;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 9;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_OUT_WIDTH = 256;
  localparam int DEF_MAX_WINDOW    = 16;
  localparam int DEF_PIXEL_BITS    = 16;

  // -1.0 in the accumulator format
  localparam logic signed [ACC_W-1:0] MINUS_ONE = ACC_W'(-(2 ** FRAC_BITS));

  // Pooling modes
  localparam logic MODE_MAX = 1'b0;
  localparam logic MODE_AVG = 1'b1;

  // Register reset values
  localparam logic                 RST_POOL_MODE     = MODE_MAX;
  localparam logic [WIN_REG_W-1:0] RST_WINDOW_WIDTH  = WIN_REG_W'(2);
  localparam logic [WIN_REG_W-1:0] RST_WINDOW_HEIGHT = WIN_REG_W'(2);
  localparam logic [OUT_REG_W-1:0] RST_POOLED_WIDTH  = OUT_REG_W'(16);
  localparam logic [OUT_REG_W-1:0] RST_POOLED_HEIGHT = OUT_REG_W'(16);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_POOL_MODE     = 3'd0,
    CFG_WINDOW_WIDTH  = 3'd1,
    CFG_WINDOW_HEIGHT = 3'd2,
    CFG_POOLED_WIDTH  = 3'd3,
    CFG_POOLED_HEIGHT = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic                 pool_mode;
    logic [WIN_REG_W-1:0] window_width;
    logic [WIN_REG_W-1:0] window_height;
    logic [OUT_REG_W-1:0] pooled_width;
    logic [OUT_REG_W-1:0] pooled_height;
  } cfg_t;

  typedef enum logic {
    F_IDLE,
    F_UPDATE
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } back_state_t;

  // Index width for a count of v entries, at least one bit
  function automatic int bits_for(input int v);
    return (v <= 1) ? 1 : $clog2(v);
  endfunction

endpackage

`default_nettype wire

@@ sv/wpool_front.sv @@
// ----------------------------------------------------------------------------
// wpool_front: pixel intake and column accumulation
// Tracks the window position, updates the column accumulator memory and
// hands each closed window to the queue as a job.
// ----------------------------------------------------------------------------
`default_nettype none

module wpool_front #(
  parameter int MAX_OUT_WIDTH = 256,
  parameter int MAX_WINDOW    = 16,
  parameter int PIXEL_BITS    = 16,
  parameter int JOB_W         = 44
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wpool_pkg::cfg_t                     cfg,
  input  wire                                 pix_valid,
  output logic                                pix_ready,
  input  wire  signed [PIXEL_BITS-1:0]        pix_in,
  output logic                                job_valid,
  input  wire                                 job_ready,
  output logic [JOB_W-1:0]                    job_data
);
  import wpool_pkg::*;

  localparam int WW_W  = $clog2(MAX_WINDOW + 1);
  localparam int DIV_W = 2 * WW_W;
  localparam int WC_W  = bits_for(MAX_WINDOW);
  localparam int OC_W  = bits_for(MAX_OUT_WIDTH);
  localparam int PW_W  = $clog2(MAX_OUT_WIDTH + 1);

  function automatic logic [WW_W-1:0] clamp_win(input logic [WIN_REG_W-1:0] r);
    if (r == '0) return WW_W'(1);
    if (int'(r) > MAX_WINDOW) return WW_W'(MAX_WINDOW);
    return WW_W'(r);
  endfunction

  function automatic logic [PW_W-1:0] clamp_out(input logic [OUT_REG_W-1:0] r);
    if (r == '0) return PW_W'(1);
    if (int'(r) > MAX_OUT_WIDTH) return PW_W'(MAX_OUT_WIDTH);
    return PW_W'(r);
  endfunction

  front_state_t state, state_next;

  logic signed [PIXEL_BITS-1:0] pix;
  logic signed [ACC_W-1:0]      mem [MAX_OUT_WIDTH];
  logic signed [ACC_W-1:0]      rd_data;

  logic [WC_W-1:0] window_column;
  logic [WC_W-1:0] window_row;
  logic [OC_W-1:0] output_column;
  logic [OC_W-1:0] output_row;

  logic [WW_W-1:0]  ww, wh;
  logic [PW_W-1:0]  pw, ph;
  logic [DIV_W-1:0] win_size;

  logic start, col_end, row_last, out_col_end, out_row_last, close;
  logic commit;

  logic signed [ACC_W-1:0] px_ext;
  logic signed [ACC_W-1:0] max_base;
  logic signed [ACC_W-1:0] acc_max;
  logic signed [ACC_W:0]   sum;
  logic signed [ACC_W-1:0] sum_sat;
  logic signed [ACC_W-1:0] acc_new;

  always_comb begin
    ww       = clamp_win(cfg.window_width);
    wh       = clamp_win(cfg.window_height);
    pw       = clamp_out(cfg.pooled_width);
    ph       = clamp_out(cfg.pooled_height);
    win_size = DIV_W'(ww) * DIV_W'(wh);

    start        = (window_row == '0) && (window_column == '0);
    col_end      = (int'(window_column) + 1) >= int'(ww);
    row_last     = (int'(window_row) + 1) >= int'(wh);
    out_col_end  = (int'(output_column) + 1) >= int'(pw);
    out_row_last = (int'(output_row) + 1) >= int'(ph);
    close        = col_end && row_last;

    // max: first pixel of a window starts from -1.0
    px_ext   = ACC_W'(pix);
    max_base = start ? MINUS_ONE : rd_data;
    acc_max  = (px_ext > max_base) ? px_ext : max_base;

    // average: saturating running sum
    sum = {rd_data[ACC_W-1], rd_data} + {px_ext[ACC_W-1], px_ext};
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      sum_sat = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sum_sat = sum[ACC_W-1:0];
    end

    if (cfg.pool_mode == MODE_AVG) begin
      acc_new = start ? px_ext : sum_sat;
    end else begin
      acc_new = acc_max;
    end

    job_data = {out_col_end && out_row_last, cfg.pool_mode, win_size, acc_new};
  end

  // FSM: take a pixel (memory read issued), then update and commit
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pix_ready  = 1'b0;
    job_valid  = 1'b0;
    commit     = 1'b0;
    case (state)
      F_IDLE: begin
        pix_ready = 1'b1;
        if (pix_valid) state_next = F_UPDATE;
      end
      F_UPDATE: begin
        job_valid = close;
        commit    = !close || job_ready;
        if (commit) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pix_valid && pix_ready) pix <= pix_in;
  end

  // Column accumulators: one registered read per cycle, one write per commit
  always_ff @(posedge clk) begin
    if (commit) mem[output_column] <= acc_new;
    rd_data <= mem[output_column];
  end

  // Position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      window_column <= '0;
      window_row    <= '0;
      output_column <= '0;
      output_row    <= '0;
    end else if (commit) begin
      if (col_end) begin
        window_column <= '0;
        if (out_col_end) begin
          output_column <= '0;
          if (row_last) begin
            window_row <= '0;
            output_row <= out_row_last ? '0 : output_row + 1'b1;
          end else begin
            window_row <= window_row + 1'b1;
          end
        end else begin
          output_column <= output_column + 1'b1;
        end
      end else begin
        window_column <= window_column + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/wpool_queue.sv @@
// ----------------------------------------------------------------------------
// wpool_queue: short job queue between front and back
// Register-based FIFO with first-word output.
// ----------------------------------------------------------------------------
`default_nettype none

module wpool_queue #(
  parameter int DATA_W = 44,
  parameter int DEPTH  = 2
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire  [DATA_W-1:0] in_data,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [DATA_W-1:0] out_data
);
  import wpool_pkg::*;

  localparam int PTR_W = bits_for(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wptr, rptr;
  logic [CNT_W-1:0]  count;
  logic              push, pop;

  assign in_ready  = int'(count) < DEPTH;
  assign out_valid = count != '0;
  assign out_data  = slots[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (int'(wptr) == DEPTH - 1) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (int'(rptr) == DEPTH - 1) ? '0 : rptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/wpool_back.sv @@
// ----------------------------------------------------------------------------
// wpool_back: result stage
// Divides average sums by the window size (restoring, one bit per cycle),
// saturates to the pixel range and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wpool_back #(
  parameter int MAX_WINDOW = 16,
  parameter int PIXEL_BITS = 16,
  parameter int JOB_W      = 44,
  parameter int TDATA_W    = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                job_valid,
  output logic               job_ready,
  input  wire  [JOB_W-1:0]   job_data,
  output logic               m_tvalid,
  input  wire                m_tready,
  output logic [TDATA_W-1:0] m_tdata,
  output logic               m_tlast
);
  import wpool_pkg::*;

  localparam int WW_W  = $clog2(MAX_WINDOW + 1);
  localparam int DIV_W = 2 * WW_W;
  localparam int STEP_W = bits_for(ACC_W);
  localparam logic signed [ACC_W:0] PIX_HI =
    (ACC_W + 1)'((64'sd1 <<< (PIXEL_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W:0] PIX_LO = -PIX_HI - 1;

  function automatic logic signed [PIXEL_BITS-1:0] sat_pixel(
    input logic signed [ACC_W:0] v);
    if (v > PIX_HI) return PIXEL_BITS'(PIX_HI);
    if (v < PIX_LO) return PIXEL_BITS'(PIX_LO);
    return PIXEL_BITS'(v);
  endfunction

  back_state_t state, state_next;

  logic signed [ACC_W-1:0] acc;
  logic [DIV_W-1:0]        divisor;
  logic                    avg;
  logic                    last;
  logic                    neg;
  logic [ACC_W-1:0]        quo;
  logic [DIV_W-1:0]        rem;
  logic [STEP_W-1:0]       step;

  logic                    take, load_out;
  logic [DIV_W:0]          trial;
  logic                    ge;
  logic [DIV_W:0]          diff;
  logic signed [ACC_W:0]   quo_ext;
  logic signed [ACC_W:0]   value;
  logic signed [PIXEL_BITS-1:0] result;

  always_comb begin
    trial   = {rem, quo[ACC_W-1]};
    ge      = trial >= {1'b0, divisor};
    diff    = trial - {1'b0, divisor};
    quo_ext = {1'b0, quo};
    if (avg) begin
      value = neg ? -quo_ext : quo_ext;
    end else begin
      value = {acc[ACC_W-1], acc};
    end
    result = sat_pixel(value);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    job_ready  = 1'b0;
    take       = 1'b0;
    load_out   = 1'b0;
    case (state)
      B_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          take       = 1'b1;
          state_next = job_data[ACC_W+DIV_W] ? B_DIV : B_DONE;
        end
      end
      B_DIV: begin
        if (int'(step) == ACC_W - 1) state_next = B_DONE;
      end
      B_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Job capture and divider iterations
  always_ff @(posedge clk) begin
    if (take) begin
      acc     <= job_data[ACC_W-1:0];
      divisor <= job_data[ACC_W +: DIV_W];
      avg     <= job_data[ACC_W+DIV_W];
      last    <= job_data[ACC_W+DIV_W+1];
      neg     <= job_data[ACC_W-1];
      quo     <= job_data[ACC_W-1] ? -job_data[ACC_W-1:0] : job_data[ACC_W-1:0];
      rem     <= '0;
      step    <= '0;
    end else if (state == B_DIV) begin
      rem  <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo  <= {quo[ACC_W-2:0], ge};
      step <= step + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= TDATA_W'($unsigned(result));
      m_tlast <= last;
    end
  end

endmodule

`default_nettype wire

@@ sv/window_pooling.sv @@
// ----------------------------------------------------------------------------
// window_pooling: non-overlapping 2D max / average pooling on a pixel stream
// Raster-order pixels in, one pooled value out per closed window.
// ----------------------------------------------------------------------------
// Usage
//   Slave stream: s_tdata[PIXEL_BITS-1:0] carries one signed pixel (12
//   fraction bits) per transaction, raster order, pooled_width*window_width
//   pixels per input row.
//   Master stream: one transaction per window; tdata is the pooled value,
//   tlast marks the last output pixel of a frame.
//   Config port: cfg_we writes cfg_data into register cfg_index (0 mode,
//   1 window width, 2 window height, 3 pooled width, 4 pooled height).
//   Write it only while the block is idle.
// Dataflow
//   Each pixel passes two front states: accept with the accumulator memory
//   read, then update and write-back; the next pixel waits for the commit.
//   Max results pass the queue, the back's done state and the output
//   register. Average results first pass a one-bit-per-cycle restoring
//   divider (32 steps); the back takes no new job until a result is loaded.
//   A 2-entry job queue lets the front run on while the divider works.
// Reset and stalls
//   rst clears counters, queue and config to defaults (2x2 max, 16x16 out);
//   accumulators need no clearing since every window starts by overwriting.
//   A stalled receiver holds the output register; the back stops, the queue
//   fills, and then s_tready drops until room frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module window_pooling #(
  parameter int MAX_OUT_WIDTH = wpool_pkg::DEF_MAX_OUT_WIDTH,
  parameter int MAX_WINDOW    = wpool_pkg::DEF_MAX_WINDOW,
  parameter int PIXEL_BITS    = wpool_pkg::DEF_PIXEL_BITS
) (
  input  wire                                       clk,
  input  wire                                       rst,
  // config write port
  input  wire                                       cfg_we,
  input  wire  [wpool_pkg::CFG_INDEX_W-1:0]         cfg_index,
  input  wire  [wpool_pkg::CFG_DATA_W-1:0]          cfg_data,
  // pixel input
  input  wire                                       s_tvalid,
  output logic                                      s_tready,
  input  wire  [((PIXEL_BITS+7)/8)*8-1:0]           s_tdata,  // [PIXEL_BITS-1:0] pixel
  // pooled output
  output logic                                      m_tvalid,
  input  wire                                       m_tready,
  output logic [((PIXEL_BITS+7)/8)*8-1:0]           m_tdata,  // [PIXEL_BITS-1:0] pooled_value
  output logic                                      m_tlast   // frame_last
);
  import wpool_pkg::*;

  localparam int TDATA_W = ((PIXEL_BITS + 7) / 8) * 8;
  localparam int WW_W    = $clog2(MAX_WINDOW + 1);
  localparam int DIV_W   = 2 * WW_W;
  // job = {frame_last, avg_mode, window size, accumulator}
  localparam int JOB_W   = ACC_W + DIV_W + 2;
  localparam int Q_DEPTH = 2;

  cfg_t cfg;

  logic             fj_valid, fj_ready;
  logic [JOB_W-1:0] fj_data;
  logic             bj_valid, bj_ready;
  logic [JOB_W-1:0] bj_data;

  // Configuration registers; fields take the low bits of the write data
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pool_mode     <= RST_POOL_MODE;
      cfg.window_width  <= RST_WINDOW_WIDTH;
      cfg.window_height <= RST_WINDOW_HEIGHT;
      cfg.pooled_width  <= RST_POOLED_WIDTH;
      cfg.pooled_height <= RST_POOLED_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POOL_MODE:     cfg.pool_mode     <= cfg_data[0];
        CFG_WINDOW_WIDTH:  cfg.window_width  <= cfg_data[WIN_REG_W-1:0];
        CFG_WINDOW_HEIGHT: cfg.window_height <= cfg_data[WIN_REG_W-1:0];
        CFG_POOLED_WIDTH:  cfg.pooled_width  <= cfg_data[OUT_REG_W-1:0];
        CFG_POOLED_HEIGHT: cfg.pooled_height <= cfg_data[OUT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  wpool_front #(
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
    .MAX_WINDOW    (MAX_WINDOW),
    .PIXEL_BITS    (PIXEL_BITS),
    .JOB_W         (JOB_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pix_valid (s_tvalid),
    .pix_ready (s_tready),
    .pix_in    (s_tdata[PIXEL_BITS-1:0]),
    .job_valid (fj_valid),
    .job_ready (fj_ready),
    .job_data  (fj_data)
  );

  wpool_queue #(
    .DATA_W (JOB_W),
    .DEPTH  (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fj_valid),
    .in_ready  (fj_ready),
    .in_data   (fj_data),
    .out_valid (bj_valid),
    .out_ready (bj_ready),
    .out_data  (bj_data)
  );

  wpool_back #(
    .MAX_WINDOW (MAX_WINDOW),
    .PIXEL_BITS (PIXEL_BITS),
    .JOB_W      (JOB_W),
    .TDATA_W    (TDATA_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (bj_valid),
    .job_ready (bj_ready),
    .job_data  (bj_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

@@ sv/wpool_checker.sv @@
// ----------------------------------------------------------------------------
// wpool_checker: port-level checks for window_pooling
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wpool_checker #(
  parameter int TDATA_W = 16
) (
  input wire               clk,
  input wire               rst,
  input wire               s_tvalid,
  input wire               s_tready,
  input wire               m_tvalid,
  input wire               m_tready,
  input wire [TDATA_W-1:0] m_tdata,
  input wire               m_tlast
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid high right after reset");

  // A pixel goes through the update state after its take, so ready drops after a take
  a_pixel_two_cycles: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("pixel accepted in back-to-back cycles");

  // Stalled output keeps its transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("output dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tlast)))
    else $error("output payload changed while stalled");

endmodule

bind window_pooling wpool_checker #(.TDATA_W(TDATA_W)) u_wpool_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the window pooling block
// Streams raster-order pixels in under random source gaps and sink stalls.
// A behavioral copy of the pooling datapath predicts the pooled values and frame
// flags not given by the directed table, and a monitor checks each output in order.
// Stimulus: a short directed table, a set of size-extreme phases, then random
// phases. Each phase reprograms all registers while the block is drained.
// ----------------------------------------------------------------------------

module testbench;
  import wpool_pkg::*;

  localparam int PIXEL_BITS  = DEF_PIXEL_BITS;
  localparam int TDATA_W     = ((PIXEL_BITS + 7) / 8) * 8;
  localparam int OUT_COLS    = DEF_MAX_OUT_WIDTH;
  localparam int WIN_MAX     = DEF_MAX_WINDOW;
  localparam int ITEMS       = 1550;
  localparam int DRAIN_WAIT  = 48;       // > divider latency, covers queued jobs
  localparam int CYCLE_LIMIT = 1000000;

  typedef logic signed [PIXEL_BITS-1:0] pixel_t;

  typedef struct {
    pixel_t value;
    logic   last;
  } pooled_t;

  // One row of the directed table: either a register write or a pixel.
  // Where typed is set, the expected pooled output is given in the row itself.
  typedef struct {
    bit                    write;
    cfg_index_t            sel;
    logic [CFG_DATA_W-1:0] data;
    pixel_t                px;
    bit                    typed;
    pixel_t                want;
    logic                  want_last;
  } step_t;

  localparam int DIRECTED_ROWS = 29;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [TDATA_W-1:0]     s_tdata   = '0;   // [15:0] pixel
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [TDATA_W-1:0]     m_tdata;          // [15:0] pooled_value
  logic                   m_tlast;          // frame_last

  window_pooling dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Pooling predictor: register copy, per-column accumulators, position counters
  // --------------------------------------------------------------------------
  logic                 mode_reg = MODE_MAX;
  logic [WIN_REG_W-1:0] win_w_reg = RST_WINDOW_WIDTH;
  logic [WIN_REG_W-1:0] win_h_reg = RST_WINDOW_HEIGHT;
  logic [OUT_REG_W-1:0] out_w_reg = RST_POOLED_WIDTH;
  logic [OUT_REG_W-1:0] out_h_reg = RST_POOLED_HEIGHT;

  longint col_acc [OUT_COLS];
  int     win_col = 0;
  int     win_row = 0;
  int     out_col = 0;
  int     out_row = 0;

  pooled_t pooled_queue [$];
  int      mismatch_count = 0;
  int      pixels_sent    = 0;
  int      cycle_count    = 0;
  int      stall_left     = 0;
  bit      quiet          = 0;   // phase with no source gaps and no sink stalls

  // Size registers: zero acts as one, oversize clamps to the maximum.
  function automatic int win_size(input logic [WIN_REG_W-1:0] r);
    return (r == 0) ? 1 : ((r > WIN_MAX) ? WIN_MAX : int'(r));
  endfunction

  function automatic int out_size(input logic [OUT_REG_W-1:0] r);
    return (r == 0) ? 1 : ((r > OUT_COLS) ? OUT_COLS : int'(r));
  endfunction

  function automatic longint saturate(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // Folds one pixel into its column; returns 1 when it closes a window.
  function automatic bit pool_pixel(input pixel_t px, output pooled_t res);
    int     ww;
    int     wh;
    int     pw;
    int     ph;
    longint acc;
    longint v;
    bit     start;
    bit     col_end;
    bit     row_last;
    bit     out_col_end;
    bit     closes;
    ww          = win_size(win_w_reg);
    wh          = win_size(win_h_reg);
    pw          = out_size(out_w_reg);
    ph          = out_size(out_h_reg);
    acc         = col_acc[out_col % OUT_COLS];
    start       = (win_row == 0) && (win_col == 0);
    col_end     = win_col + 1 >= ww;
    row_last    = win_row + 1 >= wh;
    out_col_end = out_col + 1 >= pw;
    closes      = col_end && row_last;
    res         = '{value: '0, last: 1'b0};

    if (mode_reg == MODE_MAX) begin
      if (start) acc = longint'(MINUS_ONE);   // floor at -1.0
      if (longint'(px) > acc) acc = longint'(px);
    end else begin
      acc = start ? longint'(px) : acc + longint'(px);
    end
    acc = saturate(acc, ACC_W);
    col_acc[out_col % OUT_COLS] = acc;

    if (closes) begin
      v = acc;
      if (mode_reg == MODE_AVG) v = acc / longint'(ww * wh);  // truncates toward zero
      res.value = pixel_t'(saturate(v, PIXEL_BITS));
      res.last  = out_col_end && (out_row + 1 >= ph);
    end

    // counters wrap once at or past their limit
    if (col_end) begin
      win_col = 0;
      if (out_col_end) begin
        out_col = 0;
        if (row_last) begin
          win_row = 0;
          out_row = (out_row + 1 >= ph) ? 0 : out_row + 1;
        end else begin
          win_row = win_row + 1;
        end
      end else begin
        out_col = out_col + 1;
      end
    end else begin
      win_col = win_col + 1;
    end
    return closes;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  step_t directed_steps [0:DIRECTED_ROWS-1] = '{
    // single 2x2 max window per frame
    '{1'b1, CFG_POOLED_WIDTH,  9'd1, '0, 1'b0, '0, 1'b0},
    '{1'b1, CFG_POOLED_HEIGHT, 9'd1, '0, 1'b0, '0, 1'b0},
    // both pixel extremes in one window
    '{1'b0, CFG_POOL_MODE, '0, 16'sh7FFF,     1'b0, '0, 1'b0},
    '{1'b0, CFG_POOL_MODE, '0, 16'sh8000,     1'b0, '0, 1'b0},
    '{1'b0, CFG_POOL_MODE, '0, 16'sd0,        1'b0, '0, 1'b0},
    '{1'b0, CFG_POOL_MODE, '0, 16'sd100,      1'b1, 16'sh7FFF, 1'b1},
    // everything below -1.0: result is the floor
    '{1'b0, CFG_POOL_MODE, '0, 16'sh8000,     1'b0, '0, 1'b0},
    '{1'b0, CFG_POOL_MODE, '0, -16'sd5000,    1'b0, '0, 1'b0},
    '{1'b0, CFG_POOL_MODE, '0, -16'sd4097,    1'b0, '0, 1'b0},
    '{1'b0, CFG_POOL_MODE, '0, 16'sh8000,     1'b1, -16'sd4096, 1'b1},
    // negative values above the floor
    '{1'b0, CFG_POOL_MODE, '0, -16'sd1,       1'b0, '0, 1'b0},
    '{1'b0, CFG_POOL_MODE, '0, -16'sd2,       1'b0, '0, 1'b0},
    '{1'b0, CFG_POOL_MODE, '0, -16'sd3,       1'b0, '0, 1'b0},
    '{1'b0, CFG_POOL_MODE, '0, -16'sd4,       1'b1, -16'sd1, 1'b1},
    // average mode: most negative sum
    '{1'b1, CFG_POOL_MODE, 9'(MODE_AVG), '0, 1'b0, '0, 1'b0},
    '{1'b0, CFG_POOL_MODE, '0, 16'sh8000,     1'b0, '0, 1'b0},
    '{1'b0, CFG_POOL_MODE, '0, 16'sh8000,     1'b0, '0, 1'b0},
    '{1'b0, CFG_POOL_MODE, '0, 16'sh8000,     1'b0, '0, 1'b0},
    '{1'b0, CFG_POOL_MODE, '0, 16'sh8000,     1'b1, 16'sh8000, 1'b1},
    // -3/4 truncates toward zero
    '{1'b0, CFG_POOL_MODE, '0, -16'sd1,       1'b0, '0, 1'b0},
    '{1'b0, CFG_POOL_MODE, '0, 16'sd0,        1'b0, '0, 1'b0},
    '{1'b0, CFG_POOL_MODE, '0, 16'sd0,        1'b0, '0, 1'b0},
    '{1'b0, CFG_POOL_MODE, '0, -16'sd2,       1'b1, 16'sd0, 1'b1},
    // zero sizes act as one: every pixel is its own frame
    '{1'b1, CFG_WINDOW_WIDTH,  9'd0, '0, 1'b0, '0, 1'b0},
    '{1'b1, CFG_WINDOW_HEIGHT, 9'd0, '0, 1'b0, '0, 1'b0},
    '{1'b1, CFG_POOLED_WIDTH,  9'd0, '0, 1'b0, '0, 1'b0},
    '{1'b1, CFG_POOLED_HEIGHT, 9'd0, '0, 1'b0, '0, 1'b0},
    '{1'b0, CFG_POOL_MODE, '0, -16'sd7,       1'b1, -16'sd7, 1'b1},
    '{1'b0, CFG_POOL_MODE, '0, 16'sh7FFF,     1'b1, 16'sh7FFF, 1'b1}
  };

  // --------------------------------------------------------------------------
  // Source side: all tasks run from the stimulus process, at a rising edge
  // --------------------------------------------------------------------------
  task automatic write_reg(input cfg_index_t sel, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= data;
    @(posedge clk);
    case (sel)
      CFG_POOL_MODE:     mode_reg  = data[0];
      CFG_WINDOW_WIDTH:  win_w_reg = data[WIN_REG_W-1:0];
      CFG_WINDOW_HEIGHT: win_h_reg = data[WIN_REG_W-1:0];
      CFG_POOLED_WIDTH:  out_w_reg = data[OUT_REG_W-1:0];
      CFG_POOLED_HEIGHT: out_h_reg = data[OUT_REG_W-1:0];
      default: ;
    endcase
  endtask

  // Sends one pixel transaction; a typed expectation replaces the prediction.
  task automatic send_pixel(input pixel_t px, input bit typed, input pooled_t typed_res);
    int      gap;
    pooled_t res;
    bit      closes;
    cfg_we <= 1'b0;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= TDATA_W'(px);
    do @(posedge clk); while (!s_tready);
    pixels_sent++;
    closes = pool_pixel(px, res);
    if (typed) pooled_queue.push_back(typed_res);
    else if (closes) pooled_queue.push_back(res);
  endtask

  // Drain: all results in, then room for a window that is still being divided.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pooled_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic pixel_t draw_pixel(input bit neg_only);
    pixel_t corner [8] = '{16'sh7FFF, 16'sh8000, -16'sd4096, -16'sd4097,
                           -16'sd4095, 16'sd0, -16'sd1, 16'sd1};
    pixel_t px;
    case ($urandom_range(0, 7))
      0:       px = corner[$urandom_range(0, 7)];
      1, 2:    px = pixel_t'(int'($urandom_range(0, 16383)) - 8192);  // around +-2.0
      default: px = pixel_t'($urandom());
    endcase
    if (neg_only) px[PIXEL_BITS-1] = 1'b1;
    return px;
  endfunction

  // One phase: whole rows of windows, so every phase starts and ends with all
  // window and column counters at zero and no accumulator is read unwritten.
  task automatic run_phase(input logic mode, input logic [WIN_REG_W-1:0] ww,
                           input logic [WIN_REG_W-1:0] wh, input logic [OUT_REG_W-1:0] pw,
                           input logic [OUT_REG_W-1:0] ph, input int rows,
                           input bit neg_only);
    int count;
    settle();
    write_reg(CFG_POOL_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_WINDOW_WIDTH, CFG_DATA_W'(ww));
    write_reg(CFG_WINDOW_HEIGHT, CFG_DATA_W'(wh));
    write_reg(CFG_POOLED_WIDTH, CFG_DATA_W'(pw));
    write_reg(CFG_POOLED_HEIGHT, CFG_DATA_W'(ph));
    quiet = ($urandom_range(0, 4) == 0);
    count = win_size(ww) * win_size(wh) * out_size(pw) * rows;
    repeat (count) send_pixel(draw_pixel(neg_only), 1'b0, '{value: '0, last: 1'b0});
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic                 mode;
    logic [WIN_REG_W-1:0] ww;
    logic [WIN_REG_W-1:0] wh;
    logic [OUT_REG_W-1:0] pw;
    logic [OUT_REG_W-1:0] ph;
    int                   rows;
    int                   area;
    bit                   writing;
    foreach (col_acc[i]) col_acc[i] = 0;
    writing = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table, starting from the reset settings
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (directed_steps[i].write) begin
        if (!writing) settle();
        write_reg(directed_steps[i].sel, directed_steps[i].data);
        writing = 1;
      end else begin
        writing = 0;
        send_pixel(directed_steps[i].px, directed_steps[i].typed,
                   '{value: directed_steps[i].want, last: directed_steps[i].want_last});
      end
    end

    // size extremes, including out-of-range register values
    run_phase(MODE_AVG, 5'd16, 5'd16, 9'd1,   9'd2,   1, 1'b0);
    run_phase(MODE_MAX, 5'd1,  5'd1,  9'd256, 9'd256, 1, 1'b0);
    run_phase(MODE_MAX, 5'd31, 5'd0,  9'd3,   9'd511, 1, 1'b1);
    run_phase(MODE_AVG, 5'd0,  5'd31, 9'd2,   9'd0,   1, 1'b0);
    run_phase(MODE_MAX, 5'd1,  5'd1,  9'd300, 9'd1,   1, 1'b0);

    // random phases, mostly small windows and short rows
    while (pixels_sent < ITEMS) begin
      mode = ($urandom_range(0, 1) == 0) ? MODE_MAX : MODE_AVG;
      ww   = WIN_REG_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                    : $urandom_range(1, 4));
      wh   = WIN_REG_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                    : $urandom_range(1, 4));
      area = win_size(ww) * win_size(wh);
      if (area <= 4 && $urandom_range(0, 5) == 0) pw = OUT_REG_W'($urandom_range(0, 511));
      else if (area > 16) pw = OUT_REG_W'($urandom_range(1, 2));
      else pw = OUT_REG_W'($urandom_range(1, 6));
      ph   = OUT_REG_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                                    : $urandom_range(1, 4));
      rows = $urandom_range(1, 4);
      if (area * out_size(pw) * rows > 300) rows = 1;
      run_phase(mode, ww, wh, pw, ph, rows, $urandom_range(0, 3) == 0);
    end

    quiet = 0;
    settle();
    if (mismatch_count == 0) begin
      $display("PASS window_pooling");
    end else begin
      $display("FAIL window_pooling");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sink side: random stall after each output transaction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : sink_ready
    bit ready_nxt;
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      ready_nxt  = (stall_left == 0);
    end else if (m_tvalid && m_tready) begin
      stall_left = quiet ? 0 : $urandom_range(0, 3);
      ready_nxt  = (stall_left == 0);
    end else begin
      ready_nxt = 1'b1;
    end
    m_tready <= ready_nxt;
  end

  // --------------------------------------------------------------------------
  // Output check, in order against the oldest expectation
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("[%0t ns] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : result_check
    pooled_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pooled_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%0d last=%0b",
                                  $signed(m_tdata[PIXEL_BITS-1:0]), m_tlast));
      end else begin
        want = pooled_queue.pop_front();
        if (m_tdata[PIXEL_BITS-1:0] !== want.value)
          report_mismatch($sformatf("pooled_value got %0d want %0d",
                                    $signed(m_tdata[PIXEL_BITS-1:0]), want.value));
        if (m_tlast !== want.last)
          report_mismatch($sformatf("frame_last got %0b want %0b", m_tlast, want.last));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL window_pooling");
      $finish;
    end
  end

endmodule

@@ filelist.f @@
sv/wpool_pkg.sv
sv/wpool_front.sv
sv/wpool_queue.sv
sv/wpool_back.sv
sv/window_pooling.sv
sv/wpool_checker.sv
test/testbench.sv
